// ===== hw/rtl/htc_pkg.sv =====
package htc_pkg;

  // one clip-space vertex, index 0..3 is x, y, z, w
  typedef logic [3:0][31:0] vtx_t;

  localparam int unsigned NUM_PLANES = 6;
  localparam int unsigned AXIS_W     = 3;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PL_START,
    ST_PL_FIRST,
    ST_RD_V2,
    ST_LATCH,
    ST_EVAL,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_WR_CROSS,
    ST_WR_V2,
    ST_ADV,
    ST_PL_NEXT,
    ST_OUT_START,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_HOLD
  } state_t;

endpackage

// ===== hw/rtl/homogeneous_triangle_clipper.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+----------------------------------------------
// input    | in_valid  | in_stall  | in_{first,second,third}_{x,y,z,w}
// result   | out_valid | out_stall | out_x/y/z/w, out_corner, out_last_of_run
//
// one triangle at a time; in_stall stays high from acceptance until its last vertex is taken, or until
// the clipped polygon is found to have fewer than three vertices; sequence: load the three vertices
// after acceptance, then for each plane walk every polygon edge, writing its end vertex when that is
// inside and a crossing vertex for every crossing edge (bit-serial divider then four passes of the shared multiplier)
// output: a start state, then each emitted vertex is read, loaded and held while out_stall is high
// reset is synchronous, active low, and clears the sequencer and the polygon vertex counts
module homogeneous_triangle_clipper #(
  parameter int unsigned MAX_VERTICES = 9,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_first_w,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic signed [31:0] in_second_w,
  input  logic signed [31:0] in_third_x,
  input  logic signed [31:0] in_third_y,
  input  logic signed [31:0] in_third_z,
  input  logic signed [31:0] in_third_w,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [31:0] out_w,
  output logic [1:0]         out_corner,
  output logic               out_last_of_run
);
  import htc_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_VERTICES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned SW    = $clog2(FRAC_BITS + 1);
  localparam int unsigned PW    = QW + 1 + 33;

  // vertex store: two ping-pong polygons
  vtx_t vert_mem [DEPTH];
  vtx_t rd_data_r;

  state_t state_r, state_nxt;

  vtx_t              tri_r [3];
  vtx_t              tri_nxt [3];
  logic [1:0]        k_r, k_nxt;
  logic              src_r, src_nxt;
  logic [AXIS_W-1:0] plane_r, plane_nxt;
  logic [CW-1:0]     i_r, i_nxt;
  logic [CW-1:0]     cnt_r [2];
  logic [CW-1:0]     cnt_nxt [2];
  vtx_t              v1_r, v1_nxt, v2_r, v2_nxt, cross_r, cross_nxt;
  logic signed [32:0] d1_r, d1_nxt, d2_r, d2_nxt;
  logic [34:0]       rem_r, rem_nxt;
  logic [33:0]       den_r, den_nxt;
  logic [QW-1:0]     q_r, q_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [1:0]        axis_r, axis_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic [CW-1:0]     t_r, t_nxt;
  logic [1:0]        c_r, c_nxt;
  vtx_t              out_v_r, out_v_nxt;
  logic [1:0]        corner_r, corner_nxt;
  logic              last_r, last_nxt;

  logic              wr_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  vtx_t              wr_data;

  logic              dst;
  logic [CW-1:0]     n_src, j_idx, fan_idx;
  logic              in1, in2, room, is_last;
  logic signed [33:0] dd;
  logic [34:0]       trial;
  logic [QW-1:0]     frac;
  logic signed [32:0] diff;
  logic signed [PW-1:0] prod_sh;

  // store address of a vertex in one of the two polygons
  function automatic logic [AW-1:0] addr_of(input logic buf_sel, input logic [IW-1:0] idx);
    addr_of = AW'(idx) + (buf_sel ? AW'(MAX_VERTICES) : AW'(0));
  endfunction

  // signed distance of a vertex to the plane, w +/- coordinate
  function automatic logic signed [32:0] dist_of(input vtx_t v, input logic [AXIS_W-1:0] pl);
    logic signed [32:0] c;
    logic signed [32:0] w;
    c = 33'(signed'(v[pl[2:1]]));
    w = 33'(signed'(v[3]));
    dist_of = pl[0] ? (w - c) : (w + c);
  endfunction

  // shared helpers
  always_comb begin
    dst     = ~src_r;
    n_src   = cnt_r[src_r];
    j_idx   = (i_r + CW'(1) == n_src) ? CW'(0) : i_r + CW'(1);
    in1     = d1_r > 0;
    in2     = d2_r > 0;
    room    = cnt_r[dst] < CW'(MAX_VERTICES);
    dd      = 34'(d1_r) - 34'(d2_r);
    trial   = (step_r == SW'(0)) ? rem_r : {rem_r[33:0], 1'b0};
    frac    = (den_r == 34'd0) ? QW'(0) : q_r;
    diff    = 33'(signed'(v2_r[axis_r])) - 33'(signed'(v1_r[axis_r]));
    prod_sh = prod_r >>> FRAC_BITS;
    is_last = (t_r + CW'(2) == n_src) && (c_r == 2'd2);
    case (c_r)
      2'd0:    fan_idx = CW'(0);
      2'd1:    fan_idx = t_r;
      default: fan_idx = t_r + CW'(1);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:      if (k_r == 2'd2) state_nxt = ST_PL_START;
      ST_PL_START:  state_nxt = (n_src == CW'(0)) ? ST_PL_NEXT : ST_PL_FIRST;
      ST_PL_FIRST:  state_nxt = ST_RD_V2;
      ST_RD_V2:     state_nxt = ST_LATCH;
      ST_LATCH:     state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (in1 != in2) state_nxt = ST_DIV;
        else if (in1) state_nxt = ST_WR_V2;
        else state_nxt = ST_ADV;
      end
      ST_DIV:       if (step_r == SW'(FRAC_BITS)) state_nxt = ST_MUL;
      ST_MUL:       state_nxt = ST_ADD;
      ST_ADD:       state_nxt = (axis_r == 2'd3) ? ST_WR_CROSS : ST_MUL;
      ST_WR_CROSS:  state_nxt = in2 ? ST_WR_V2 : ST_ADV;
      ST_WR_V2:     state_nxt = ST_ADV;
      ST_ADV:       state_nxt = (i_r + CW'(1) == n_src) ? ST_PL_NEXT : ST_RD_V2;
      ST_PL_NEXT: begin
        state_nxt = (plane_r == AXIS_W'(NUM_PLANES - 1)) ? ST_OUT_START : ST_PL_START;
      end
      ST_OUT_START: state_nxt = (n_src < CW'(3)) ? ST_IDLE : ST_OUT_RD;
      ST_OUT_RD:    state_nxt = ST_OUT_LD;
      ST_OUT_LD:    state_nxt = ST_OUT_HOLD;
      ST_OUT_HOLD: begin
        if (!out_stall) state_nxt = last_r ? ST_IDLE : ST_OUT_RD;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshakes and store ports
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT_HOLD);
    wr_en     = 1'b0;
    wr_addr   = addr_of(dst, cnt_r[dst][IW-1:0]);
    wr_data   = v2_r;
    rd_addr   = addr_of(src_r, IW'(0));
    case (state_r)
      ST_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = addr_of(1'b0, IW'(k_r));
        wr_data = tri_r[k_r];
      end
      ST_RD_V2:    rd_addr = addr_of(src_r, j_idx[IW-1:0]);
      ST_WR_CROSS: begin
        wr_en   = room;
        wr_data = cross_r;
      end
      ST_WR_V2:    wr_en = room;
      ST_OUT_RD:   rd_addr = addr_of(src_r, fan_idx[IW-1:0]);
      default:     wr_en = 1'b0;
    endcase
  end

  // datapath next values
  always_comb begin
    tri_nxt    = tri_r;
    k_nxt      = k_r;
    src_nxt    = src_r;
    plane_nxt  = plane_r;
    i_nxt      = i_r;
    cnt_nxt    = cnt_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    cross_nxt  = cross_r;
    d1_nxt     = d1_r;
    d2_nxt     = d2_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    q_nxt      = q_r;
    step_nxt   = step_r;
    axis_nxt   = axis_r;
    prod_nxt   = prod_r;
    t_nxt      = t_r;
    c_nxt      = c_r;
    out_v_nxt  = out_v_r;
    corner_nxt = corner_r;
    last_nxt   = last_r;
    case (state_r)
      ST_IDLE: begin
        tri_nxt[0] = {in_first_w, in_first_z, in_first_y, in_first_x};
        tri_nxt[1] = {in_second_w, in_second_z, in_second_y, in_second_x};
        tri_nxt[2] = {in_third_w, in_third_z, in_third_y, in_third_x};
        k_nxt      = 2'd0;
        src_nxt    = 1'b0;
        plane_nxt  = '0;
      end
      ST_LOAD: begin
        k_nxt      = k_r + 2'd1;
        cnt_nxt[0] = CW'(k_r) + CW'(1);
      end
      ST_PL_START: begin
        cnt_nxt[dst] = CW'(0);
        i_nxt        = CW'(0);
      end
      ST_PL_FIRST: v1_nxt = rd_data_r;
      ST_LATCH: begin
        v2_nxt = rd_data_r;
        d1_nxt = dist_of(v1_r, plane_r);
        d2_nxt = dist_of(rd_data_r, plane_r);
      end
      ST_EVAL: begin
        rem_nxt  = {2'b00, (d1_r < 0) ? -d1_r : d1_r};
        den_nxt  = (dd < 0) ? -dd : dd;
        q_nxt    = '0;
        step_nxt = '0;
        axis_nxt = 2'd0;
      end
      // restoring division, one quotient bit a cycle
      ST_DIV: begin
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = trial - {1'b0, den_r};
          q_nxt   = {q_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[QW-2:0], 1'b0};
        end
        step_nxt = step_r + SW'(1);
      end
      ST_MUL: prod_nxt = $signed({1'b0, frac}) * diff;
      ST_ADD: begin
        cross_nxt[axis_r] = v1_r[axis_r] + prod_sh[31:0];
        axis_nxt          = axis_r + 2'd1;
      end
      ST_WR_CROSS: if (room) cnt_nxt[dst] = cnt_r[dst] + CW'(1);
      ST_WR_V2:    if (room) cnt_nxt[dst] = cnt_r[dst] + CW'(1);
      ST_ADV: begin
        v1_nxt = v2_r;
        i_nxt  = i_r + CW'(1);
      end
      ST_PL_NEXT: begin
        src_nxt   = ~src_r;
        plane_nxt = plane_r + AXIS_W'(1);
      end
      ST_OUT_START: begin
        t_nxt = CW'(1);
        c_nxt = 2'd0;
      end
      ST_OUT_LD: begin
        out_v_nxt  = rd_data_r;
        corner_nxt = c_r;
        last_nxt   = is_last;
      end
      // advance through the fan once the vertex is taken
      ST_OUT_HOLD: begin
        if (!out_stall) begin
          if (c_r == 2'd2) begin
            c_nxt = 2'd0;
            t_nxt = t_r + CW'(1);
          end else begin
            c_nxt = c_r + 2'd1;
          end
        end
      end
      default: k_nxt = k_r;
    endcase
  end

  // vertex store ports
  always_ff @(posedge clk) begin
    if (wr_en) vert_mem[wr_addr] <= wr_data;
    rd_data_r <= vert_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tri_r    <= tri_nxt;
    k_r      <= k_nxt;
    src_r    <= src_nxt;
    plane_r  <= plane_nxt;
    i_r      <= i_nxt;
    v1_r     <= v1_nxt;
    v2_r     <= v2_nxt;
    cross_r  <= cross_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    q_r      <= q_nxt;
    step_r   <= step_nxt;
    axis_r   <= axis_nxt;
    prod_r   <= prod_nxt;
    t_r      <= t_nxt;
    c_r      <= c_nxt;
    out_v_r  <= out_v_nxt;
    corner_r <= corner_nxt;
    last_r   <= last_nxt;
  end

  assign out_x           = out_v_r[0];
  assign out_y           = out_v_r[1];
  assign out_z           = out_v_r[2];
  assign out_w           = out_v_r[3];
  assign out_corner      = corner_r;
  assign out_last_of_run = last_r;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_VERTS = 9;
  localparam int FRAC      = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  // one expected output vertex
  typedef struct {
    logic [31:0] x, y, z, w;
    logic [1:0]  corner;
    logic        last;
  } clip_vertex_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [31:0] in_first_x = '0, in_first_y = '0, in_first_z = '0, in_first_w = '0;
  logic signed [31:0] in_second_x = '0, in_second_y = '0, in_second_z = '0, in_second_w = '0;
  logic signed [31:0] in_third_x = '0, in_third_y = '0, in_third_z = '0, in_third_w = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z, out_w;
  logic [1:0]  out_corner;
  logic        out_last_of_run;

  int   error_count = 0;
  bit   sending_done = 0;
  bit   hold_off = 0;
  longint cycle_count = 0;

  homogeneous_triangle_clipper #(.MAX_VERTICES(MAX_VERTS), .FRAC_BITS(FRAC)) dut (.*);

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // fan-triangulated clip predictor and queue of pending vertices
  class clip_scoreboard;
    clip_vertex_t pending_vertices[$];
    longint px[2][MAX_VERTS], py[2][MAX_VERTS], pz[2][MAX_VERTS], pw[2][MAX_VERTS];
    int     vcount[2];

    function longint axis_of(int b, int i, int a);
      case (a)
        0: return px[b][i];
        1: return py[b][i];
        2: return pz[b][i];
        default: return pw[b][i];
      endcase
    endfunction

    function void append(int b, longint v[4]);
      if (vcount[b] < MAX_VERTS) begin
        px[b][vcount[b]] = v[0];
        py[b][vcount[b]] = v[1];
        pz[b][vcount[b]] = v[2];
        pw[b][vcount[b]] = v[3];
        vcount[b]++;
      end
    endfunction

    function longint plane_dist(int b, int i, int plane);
      longint c, w;
      c = axis_of(b, i, plane >> 1);
      w = axis_of(b, i, 3);
      return (plane & 1) ? w - c : w + c;
    endfunction

    function void clip_against(int src, int dst, int plane);
      int n, j;
      longint d1, d2, num, den, frac, p1, prod;
      longint v2[4], crossing[4];
      bit in1, in2;
      n = vcount[src];
      vcount[dst] = 0;
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        d1 = plane_dist(src, i, plane);
        d2 = plane_dist(src, j, plane);
        in1 = d1 > 0;
        in2 = d2 > 0;
        for (int a = 0; a < 4; a++) v2[a] = axis_of(src, j, a);
        if (in1 != in2) begin
          num = d1 < 0 ? -d1 : d1;
          den = (d1 - d2) < 0 ? d2 - d1 : d1 - d2;
          frac = den != 0 ? (num <<< FRAC) / den : 0;
          for (int a = 0; a < 4; a++) begin
            p1 = axis_of(src, i, a);
            prod = frac * (v2[a] - p1);
            crossing[a] = p1 + (prod >>> FRAC);
          end
        end
        if (in1) begin
          if (in2) append(dst, v2);
          else append(dst, crossing);
        end else if (in2) begin
          append(dst, crossing);
          append(dst, v2);
        end
      end
    endfunction

    function void note_request(logic signed [31:0] tri_in[12]);
      longint v[4];
      int src, n, idx[3];
      clip_vertex_t e;
      src = 0;
      vcount[0] = 0;
      for (int k = 0; k < 3; k++) begin
        for (int a = 0; a < 4; a++) v[a] = tri_in[k * 4 + a];
        append(0, v);
      end
      for (int plane = 0; plane < 6; plane++) begin
        clip_against(src, src ^ 1, plane);
        src ^= 1;
      end
      n = vcount[src];
      if (n < 3) return;
      for (int t = 1; t + 1 < n; t++) begin
        idx[0] = 0; idx[1] = t; idx[2] = t + 1;
        for (int c = 0; c < 3; c++) begin
          e.x = 32'(axis_of(src, idx[c], 0));
          e.y = 32'(axis_of(src, idx[c], 1));
          e.z = 32'(axis_of(src, idx[c], 2));
          e.w = 32'(axis_of(src, idx[c], 3));
          e.corner = 2'(c);
          e.last = (t + 2 == n && c == 2);
          pending_vertices.insert(pending_vertices.size(), e);
        end
      end
    endfunction

    task check_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [31:0] w, logic [1:0] corner, logic last);
      clip_vertex_t e;
      if (pending_vertices.size() == 0) begin
        report_mismatch("vertex with nothing expected");
        return;
      end
      e = pending_vertices.pop_front();
      if (x !== e.x) report_mismatch($sformatf("x got %h want %h", x, e.x));
      if (y !== e.y) report_mismatch($sformatf("y got %h want %h", y, e.y));
      if (z !== e.z) report_mismatch($sformatf("z got %h want %h", z, e.z));
      if (w !== e.w) report_mismatch($sformatf("w got %h want %h", w, e.w));
      if (corner !== e.corner)
        report_mismatch($sformatf("corner got %0d want %0d", corner, e.corner));
      if (last !== e.last)
        report_mismatch($sformatf("last got %0b want %0b", last, e.last));
    endtask
  endclass

  clip_scoreboard sb = new();

  // random Q16.16 value: mostly near the unit cube, sometimes any 32 bits
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
      default: return $signed($urandom_range(0, 3 << 16)) - (3 << 15);
    endcase
  endfunction

  // drive one request and wait for acceptance; valid stays up until the next gap
  task automatic send_triangle(input logic signed [31:0] t[12]);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_first_x <= t[0];  in_first_y <= t[1];  in_first_z <= t[2];  in_first_w <= t[3];
    in_second_x <= t[4]; in_second_y <= t[5]; in_second_z <= t[6]; in_second_w <= t[7];
    in_third_x <= t[8];  in_third_y <= t[9];  in_third_z <= t[10]; in_third_w <= t[11];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(t);
  endtask

  function automatic void make_vertex(ref logic signed [31:0] t[12], input int k,
                                      input longint x, y, z, w);
    t[k*4] = 32'(x); t[k*4+1] = 32'(y); t[k*4+2] = 32'(z); t[k*4+3] = 32'(w);
  endfunction

  // stimulus
  initial begin
    logic signed [31:0] t[12];
    localparam int ONE = 1 << 16;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // inside, fully outside, partially clipped, straddling every plane, extremes
    make_vertex(t, 0, 0, 0, 0, ONE); make_vertex(t, 1, ONE/2, 0, 0, ONE);
    make_vertex(t, 2, 0, ONE/2, 0, ONE); send_triangle(t);
    make_vertex(t, 0, 3*ONE, 0, 0, ONE); make_vertex(t, 1, 4*ONE, 0, 0, ONE);
    make_vertex(t, 2, 3*ONE, ONE, 0, ONE); send_triangle(t);
    make_vertex(t, 0, 0, 0, 0, ONE); make_vertex(t, 1, 2*ONE, 0, 0, ONE);
    make_vertex(t, 2, 0, 2*ONE, 0, ONE); send_triangle(t);
    make_vertex(t, 0, -3*ONE, -3*ONE, -3*ONE, ONE);
    make_vertex(t, 1, 3*ONE, -3*ONE, 3*ONE, ONE);
    make_vertex(t, 2, 0, 3*ONE, 0, ONE); send_triangle(t);
    make_vertex(t, 0, -5*ONE, -5*ONE, 0, ONE); make_vertex(t, 1, 5*ONE, -5*ONE, 0, ONE);
    make_vertex(t, 2, 0, 9*ONE, 0, ONE); send_triangle(t);
    // vertex on a plane (zero distance counts as outside)
    make_vertex(t, 0, ONE, 0, 0, ONE); make_vertex(t, 1, 0, ONE, 0, ONE);
    make_vertex(t, 2, 0, 0, ONE, ONE); send_triangle(t);
    make_vertex(t, 0, 0, 0, 0, 0); make_vertex(t, 1, 0, 0, 0, 0);
    make_vertex(t, 2, 0, 0, 0, 0); send_triangle(t);
    make_vertex(t, 0, 0, 0, 0, -ONE); make_vertex(t, 1, 0, 0, 0, ONE);
    make_vertex(t, 2, ONE/4, 0, 0, ONE); send_triangle(t);
    for (int i = 0; i < 12; i++) t[i] = 32'sh7fffffff;
    send_triangle(t);
    for (int i = 0; i < 12; i++) t[i] = 32'sh80000000;
    send_triangle(t);
    for (int i = 0; i < 12; i++) t[i] = (i % 4 == 3) ? 32'sh7fffffff : 32'sh80000000;
    send_triangle(t);
    make_vertex(t, 0, 32'sh80000000, 0, 0, 32'sh7fffffff);
    make_vertex(t, 1, 32'sh7fffffff, 0, 0, 32'sh7fffffff);
    make_vertex(t, 2, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff); send_triangle(t);
    // random triangles, w mostly positive so clipping does real work
    for (int n = 0; n < 170; n++) begin
      for (int k = 0; k < 3; k++) begin
        for (int a = 0; a < 3; a++) t[k*4+a] = rand_coord();
        t[k*4+3] = ($urandom_range(0, 7) == 0) ? rand_coord()
                                                : $signed($urandom_range(ONE/8, 2*ONE));
      end
      if (n == 60) hold_off = 1;
      send_triangle(t);
    end
    in_valid <= 1'b0;
    sending_done = 1;
  end

  // receiver stall, with one long hold-off
  initial begin
    int gap;
    wait (rst_n);
    forever begin
      if (hold_off) begin
        hold_off = 0;
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_vertex(out_x, out_y, out_z, out_w, out_corner, out_last_of_run);
  end

  // completion and timeout
  initial begin
    while (!(sending_done && sb.pending_vertices.size() == 0)) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (error_count == 0 && sb.pending_vertices.size() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule
